### design/cse_pkg.sv
// shared types, constants and helper functions of the cubic spline segment evaluator
`default_nettype none

package cse_pkg;

    localparam int MAX_KNOTS_DEF = 64;
    localparam int FRAC_BITS_DEF = 16;
    localparam int QUEUE_DEPTH   = 4;

    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_VALUE = 2'd1;
    localparam logic [1:0] MODE_GRAD  = 2'd2;

    localparam logic [1:0] ORDER_POINT = 2'd0;

    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_VALUE = 2'd1,
        KIND_GRAD  = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [5:0]         knot_index;
        logic [1:0]         coef_order;
        logic signed [31:0] param_value;
        logic signed [31:0] vec_x;
        logic signed [31:0] vec_y;
        logic signed [31:0] vec_z;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic signed [31:0] sat32(input logic signed [67:0] x);
        logic signed [67:0] hi;
        logic signed [67:0] lo;
        hi = $signed({36'h0, 32'h7FFFFFFF});
        lo = $signed({{36{1'b1}}, 32'h80000000});
        if (x > hi)
            return 32'sh7FFFFFFF;
        else if (x < lo)
            return 32'sh80000000;
        else
            return x[31:0];
    endfunction

endpackage

`default_nettype wire

### design/cse_ram.sv
// generic single write port ram with registered read
`default_nettype none

module cse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### design/cse_front.sv
// front end: accepts input transactions, classifies them and drops those with no effect
`default_nettype none

module cse_front
    import cse_pkg::*;
#(
    parameter int MAX_KNOTS = MAX_KNOTS_DEF
) (
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         mode,
    input  wire logic [5:0]         knot_index,
    input  wire logic [1:0]         coef_order,
    input  wire logic signed [31:0] param_value,
    input  wire logic signed [31:0] vec_x,
    input  wire logic signed [31:0] vec_y,
    input  wire logic signed [31:0] vec_z,
    input  wire q_status_t          q_status,
    output logic                    push,
    output item_t                   item
);

    logic keep;

    always_comb
    begin
        keep      = 1'b1;
        item.kind = KIND_LOAD;
        case (mode)
            MODE_LOAD:
            begin
                item.kind = KIND_LOAD;
                // loads beyond the table are ignored
                keep = (32'(knot_index) < MAX_KNOTS);
            end
            MODE_VALUE: item.kind = KIND_VALUE;
            MODE_GRAD:  item.kind = KIND_GRAD;
            default:    keep = 1'b0;
        endcase
        item.knot_index  = knot_index;
        item.coef_order  = coef_order;
        item.param_value = param_value;
        item.vec_x       = vec_x;
        item.vec_y       = vec_y;
        item.vec_z       = vec_z;
    end

    assign in_ready = !q_status.full;
    assign push     = in_valid && in_ready && keep;

endmodule

`default_nettype wire

### design/cse_queue.sv
// short fifo of classified items between the front and back ends
`default_nettype none

module cse_queue
    import cse_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire item_t push_item,
    input  wire logic  pop,
    output item_t      head,
    output q_status_t  status
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    item_t           store_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW:0]     count_reg;
    logic [PW:0]     count_next;

    assign status.full  = (count_reg == (PW+1)'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign head         = store_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            store_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

### design/cse_back.sv
// back end: table writes, segment scan and cubic evaluation with result register
`default_nettype none

module cse_back
    import cse_pkg::*;
#(
    parameter int MAX_KNOTS = MAX_KNOTS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [6:0]         knot_count,
    input  wire item_t              head,
    input  wire q_status_t          q_status,
    output logic                    pop,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [31:0]      res_x,
    output logic signed [31:0]      res_y,
    output logic signed [31:0]      res_z,
    output logic [5:0]              segment,
    output logic                    range_error
);

    localparam int AW = $clog2(MAX_KNOTS);
    localparam int NW = $clog2(MAX_KNOTS + 1);
    localparam int CW = AW + 2;

    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_FIRST = 14'b00000000000010,
        S_LAST  = 14'b00000000000100,
        S_SCAN  = 14'b00000000001000,
        S_COEF  = 14'b00000000010000,
        S_MUL_Q = 14'b00000000100000,
        S_QSTEP = 14'b00000001000000,
        S_DIV   = 14'b00000010000000,
        S_DSUM  = 14'b00000100000000,
        S_MUL_A = 14'b00001000000000,
        S_BSTEP = 14'b00010000000000,
        S_MUL_B = 14'b00100000000000,
        S_VSTEP = 14'b01000000000000,
        S_DONE  = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    // query context
    kind_t              kind_reg, kind_next;
    logic signed [31:0] p_reg, p_next;
    logic [NW-1:0]      n_reg, n_next;
    logic [AW-1:0]      s_reg, s_next;
    logic signed [31:0] base_reg, base_next;
    logic signed [32:0] d_reg, d_next;
    logic [2:0]         cnt_reg, cnt_next;
    logic               err_reg, err_next;

    // per-component lanes
    logic signed [31:0] cp_reg [3];
    logic signed [31:0] cd1_reg [3];
    logic signed [31:0] cd2_reg [3];
    logic signed [31:0] cd3_reg [3];
    logic signed [31:0] op_reg [3];
    logic signed [64:0] prod_reg [3];
    logic [33:0]        dv_reg [3];
    logic [50:0]        plo_reg [3];
    logic [50:0]        phi_reg [3];
    logic signed [31:0] r_reg [3];
    logic signed [31:0] cp_next [3];
    logic signed [31:0] cd1_next [3];
    logic signed [31:0] cd2_next [3];
    logic signed [31:0] cd3_next [3];
    logic signed [31:0] op_next [3];
    logic signed [64:0] prod_next [3];
    logic [33:0]        dv_next [3];
    logic [50:0]        plo_next [3];
    logic [50:0]        phi_next [3];
    logic signed [31:0] r_next [3];

    // output register
    logic               ov_reg, ov_next;
    logic signed [31:0] ox_reg, oy_reg, oz_reg;
    logic [5:0]         oseg_reg;
    logic               oerr_reg;

    // memories
    logic                   knot_we;
    logic [AW-1:0]          knot_waddr;
    logic [AW-1:0]          knot_raddr;
    logic [31:0]            knot_rdata;
    logic signed [31:0]     knot_q;
    logic                   coef_we;
    logic [CW-1:0]          coef_waddr;
    logic [CW-1:0]          coef_raddr;
    logic [31:0]            coef_wdata [3];
    logic [31:0]            coef_rdata [3];

    logic [AW+5:0]          kidx_w;
    logic [AW+5:0]          seg_w;
    logic [NW-1:0]          s_ext;
    logic [1:0]             rd_order;

    // lane arithmetic
    logic signed [64:0]     q3_w [3];
    logic signed [67:0]     t_w [3];
    logic signed [67:0]     tcl_w [3];
    logic signed [67:0]     u_w [3];
    logic signed [67:0]     sum_w [3];
    logic signed [67:0]     vsum_w [3];
    logic signed [31:0]     ga_w [3];
    logic [68:0]            dsum_w [3];

    localparam logic signed [67:0] T_HI = 68'sd12884901887;
    localparam logic signed [67:0] T_LO = -68'sd12884901888;
    // ceil(2^35 / 3): exact floor division by three for dividends below 2^35
    localparam logic [33:0]        RECIP3 = 34'h2AAAAAAAB;

    assign kidx_w     = (AW+6)'(head.knot_index);
    assign knot_waddr = kidx_w[AW-1:0];
    assign coef_waddr = {knot_waddr, head.coef_order};
    assign coef_wdata[0] = head.vec_x;
    assign coef_wdata[1] = head.vec_y;
    assign coef_wdata[2] = head.vec_z;
    assign knot_q     = $signed(knot_rdata);
    assign s_ext      = NW'(s_reg);
    assign seg_w      = (AW+6)'(s_reg);
    assign rd_order   = 2'(3'd3 - cnt_reg);
    assign coef_raddr = {s_reg, rd_order};

    cse_ram #(.WIDTH(32), .DEPTH(MAX_KNOTS)) u_knot_ram (
        .clk   (clk),
        .we    (knot_we),
        .waddr (knot_waddr),
        .wdata (head.param_value),
        .raddr (knot_raddr),
        .rdata (knot_rdata)
    );

    genvar gc;
    generate
        for (gc = 0; gc < 3; gc++)
        begin : g_coef
            cse_ram #(.WIDTH(32), .DEPTH(MAX_KNOTS * 4)) u_coef_ram (
                .clk   (clk),
                .we    (coef_we),
                .waddr (coef_waddr),
                .wdata (coef_wdata[gc]),
                .raddr (coef_raddr),
                .rdata (coef_rdata[gc])
            );
        end
    endgenerate

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            q3_w[c]   = prod_reg[c] >>> FRAC_BITS;
            t_w[c]    = 68'(cd2_reg[c]) + 68'(cd2_reg[c]) + 68'(cd2_reg[c]) + 68'(q3_w[c]);
            // clamping here keeps floor(t/6) exact after saturation
            tcl_w[c]  = (t_w[c] > T_HI) ? T_HI : ((t_w[c] < T_LO) ? T_LO : t_w[c]);
            u_w[c]    = tcl_w[c] - T_LO;
            ga_w[c]   = sat32(68'(cd2_reg[c]) + 68'(q3_w[c] >>> 1));
            sum_w[c]  = 68'(cd1_reg[c]) + 68'(prod_reg[c] >>> FRAC_BITS);
            vsum_w[c] = 68'(cp_reg[c]) + 68'(prod_reg[c] >>> FRAC_BITS);
            dsum_w[c] = 69'({phi_reg[c], 17'd0}) + 69'(plo_reg[c]);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        p_next     = p_reg;
        n_next     = n_reg;
        s_next     = s_reg;
        base_next  = base_reg;
        d_next     = d_reg;
        cnt_next   = cnt_reg;
        err_next   = err_reg;
        pop        = 1'b0;
        knot_we    = 1'b0;
        coef_we    = 1'b0;
        knot_raddr = '0;
        ov_next    = ov_reg;
        if (ov_reg && out_ready)
            ov_next = 1'b0;
        for (int c = 0; c < 3; c++)
        begin
            cp_next[c]   = cp_reg[c];
            cd1_next[c]  = cd1_reg[c];
            cd2_next[c]  = cd2_reg[c];
            cd3_next[c]  = cd3_reg[c];
            op_next[c]   = op_reg[c];
            prod_next[c] = prod_reg[c];
            dv_next[c]   = dv_reg[c];
            plo_next[c]  = plo_reg[c];
            phi_next[c]  = phi_reg[c];
            r_next[c]    = r_reg[c];
        end

        case (state_reg)
            S_IDLE:
            begin
                if (!q_status.empty)
                begin
                    pop = 1'b1;
                    if (head.kind == KIND_LOAD)
                    begin
                        coef_we = 1'b1;
                        knot_we = (head.coef_order == ORDER_POINT);
                    end
                    else
                    begin
                        kind_next = head.kind;
                        p_next    = head.param_value;
                        if (knot_count < 7'd2)
                            n_next = NW'(2);
                        else if (32'(knot_count) > MAX_KNOTS)
                            n_next = NW'(MAX_KNOTS);
                        else
                            n_next = NW'(knot_count);
                        state_next = S_FIRST;
                    end
                end
            end
            S_FIRST:
            begin
                s_next    = '0;
                base_next = knot_q;
                err_next  = 1'b0;
                if (p_reg < knot_q)
                begin
                    err_next   = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    knot_raddr = AW'(n_reg - 1'b1);
                    state_next = S_LAST;
                end
            end
            S_LAST:
            begin
                cnt_next = '0;
                if (p_reg > knot_q)
                begin
                    err_next   = 1'b1;
                    state_next = S_DONE;
                end
                else if (n_reg == NW'(2))
                    state_next = S_COEF;
                else
                begin
                    knot_raddr = AW'(1);
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // stop at n-2, which folds in the last-knot clamp
                if (knot_q <= p_reg)
                begin
                    s_next    = s_reg + 1'b1;
                    base_next = knot_q;
                    if ((s_ext + 1'b1) == (n_reg - NW'(2)))
                        state_next = S_COEF;
                    else
                        knot_raddr = AW'(s_reg + AW'(2));
                end
                else
                    state_next = S_COEF;
            end
            S_COEF:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 3'd0)
                    d_next = 33'(p_reg) - 33'(base_reg);
                for (int c = 0; c < 3; c++)
                begin
                    case (cnt_reg)
                        3'd1:    cd3_next[c] = $signed(coef_rdata[c]);
                        3'd2:    cd2_next[c] = $signed(coef_rdata[c]);
                        3'd3:    cd1_next[c] = $signed(coef_rdata[c]);
                        3'd4:
                        begin
                            cp_next[c] = $signed(coef_rdata[c]);
                            op_next[c] = cd3_reg[c];
                        end
                        default: ;
                    endcase
                end
                if (cnt_reg == 3'd4)
                    state_next = S_MUL_Q;
            end
            S_MUL_Q, S_MUL_A, S_MUL_B:
            begin
                for (int c = 0; c < 3; c++)
                    prod_next[c] = op_reg[c] * d_reg;
                if (state_reg == S_MUL_Q)
                    state_next = S_QSTEP;
                else if (state_reg == S_MUL_A)
                    state_next = S_BSTEP;
                else
                    state_next = S_VSTEP;
            end
            S_QSTEP:
            begin
                for (int c = 0; c < 3; c++)
                begin
                    op_next[c] = ga_w[c];
                    // floor(u/6) is floor((u/2)/3)
                    dv_next[c] = u_w[c][34:1];
                end
                state_next = (kind_reg == KIND_GRAD) ? S_MUL_A : S_DIV;
            end
            S_DIV:
            begin
                // reciprocal multiply by a third, split into two half-width products
                for (int c = 0; c < 3; c++)
                begin
                    plo_next[c] = 51'(dv_reg[c][16:0]) * 51'(RECIP3);
                    phi_next[c] = 51'(dv_reg[c][33:17]) * 51'(RECIP3);
                end
                state_next = S_DSUM;
            end
            S_DSUM:
            begin
                // quotient is biased by 2^31: flip the sign bit
                for (int c = 0; c < 3; c++)
                    op_next[c] = $signed({~dsum_w[c][66], dsum_w[c][65:35]});
                state_next = S_MUL_A;
            end
            S_BSTEP:
            begin
                for (int c = 0; c < 3; c++)
                begin
                    r_next[c]  = sat32(sum_w[c]);
                    op_next[c] = sat32(sum_w[c]);
                end
                state_next = (kind_reg == KIND_GRAD) ? S_DONE : S_MUL_B;
            end
            S_VSTEP:
            begin
                for (int c = 0; c < 3; c++)
                    r_next[c] = sat32(vsum_w[c]);
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        p_reg    <= p_next;
        n_reg    <= n_next;
        s_reg    <= s_next;
        base_reg <= base_next;
        d_reg    <= d_next;
        cnt_reg  <= cnt_next;
        err_reg  <= err_next;
        for (int c = 0; c < 3; c++)
        begin
            cp_reg[c]   <= cp_next[c];
            cd1_reg[c]  <= cd1_next[c];
            cd2_reg[c]  <= cd2_next[c];
            cd3_reg[c]  <= cd3_next[c];
            op_reg[c]   <= op_next[c];
            prod_reg[c] <= prod_next[c];
            dv_reg[c]   <= dv_next[c];
            plo_reg[c]  <= plo_next[c];
            phi_reg[c]  <= phi_next[c];
            r_reg[c]    <= r_next[c];
        end
        if (state_reg == S_DONE && (!ov_reg || out_ready))
        begin
            oerr_reg <= err_reg;
            ox_reg   <= err_reg ? 32'sd0 : r_reg[0];
            oy_reg   <= err_reg ? 32'sd0 : r_reg[1];
            oz_reg   <= err_reg ? 32'sd0 : r_reg[2];
            oseg_reg <= err_reg ? 6'd0 : seg_w[5:0];
        end
    end

    assign out_valid   = ov_reg;
    assign res_x       = ox_reg;
    assign res_y       = oy_reg;
    assign res_z       = oz_reg;
    assign segment     = oseg_reg;
    assign range_error = oerr_reg;

endmodule

`default_nettype wire

### design/cubic_spline_segment_evaluator.sv
// top level of the cubic spline segment evaluator
//
//  channel  direction  handshake            payload
//  in       input      in_valid / in_ready  mode, knot_index, coef_order, param_value, vec_x/y/z
//  out      output     out_valid/out_ready  res_x, res_y, res_z, segment, range_error
//  cfg      input      cfg_we               cfg_wdata (knot count)
//
// a load is written as it is popped; a range error goes straight to the result register.
// a value query runs a divide by six and one multiply more than a gradient query, after a
// linear segment scan that reads one knot per step (none for two knots, up to n-2 otherwise).
// mode 3 and loads beyond the table are dropped at the input and never reach the back end.
// the four-entry queue lets the input keep accepting while the back end works; a stalled
// result holds the back end in its last state. reset is asynchronous, knot count resets to 2.
`default_nettype none

module cubic_spline_segment_evaluator
    import cse_pkg::*;
#(
    parameter int MAX_KNOTS = MAX_KNOTS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         mode,
    input  wire logic [5:0]         knot_index,
    input  wire logic [1:0]         coef_order,
    input  wire logic signed [31:0] param_value,
    input  wire logic signed [31:0] vec_x,
    input  wire logic signed [31:0] vec_y,
    input  wire logic signed [31:0] vec_z,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [31:0]      res_x,
    output logic signed [31:0]      res_y,
    output logic signed [31:0]      res_z,
    output logic [5:0]              segment,
    output logic                    range_error,
    input  wire logic               cfg_we,
    input  wire logic [6:0]         cfg_wdata
);

    logic [6:0] knot_count_reg;
    logic       push;
    logic       pop;
    item_t      push_item;
    item_t      head;
    q_status_t  q_status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            knot_count_reg <= 7'd2;
        else if (cfg_we)
            knot_count_reg <= cfg_wdata;
    end

    cse_front #(.MAX_KNOTS(MAX_KNOTS)) u_front (
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .knot_index  (knot_index),
        .coef_order  (coef_order),
        .param_value (param_value),
        .vec_x       (vec_x),
        .vec_y       (vec_y),
        .vec_z       (vec_z),
        .q_status    (q_status),
        .push        (push),
        .item        (push_item)
    );

    cse_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .status    (q_status)
    );

    cse_back #(.MAX_KNOTS(MAX_KNOTS), .FRAC_BITS(FRAC_BITS)) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .knot_count  (knot_count_reg),
        .head        (head),
        .q_status    (q_status),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .res_x       (res_x),
        .res_y       (res_y),
        .res_z       (res_z),
        .segment     (segment),
        .range_error (range_error)
    );

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && range_error |-> res_x == 0 && res_y == 0 && res_z == 0 && segment == 0)
        else $error("range error result not zeroed");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_status.full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("queue read while empty");

endmodule

`default_nettype wire

### dv/cubic_spline_segment_evaluator_test.sv
// self-checking testbench of the cubic spline segment evaluator
`timescale 1ns / 100ps
`default_nettype none

module cubic_spline_segment_evaluator_test
    import cse_pkg::*;
();

    localparam int NKNOTS = 64;
    localparam int FB     = 16;

    typedef struct {
        logic [1:0]         mode;
        logic [5:0]         kidx;
        logic [1:0]         order;
        logic signed [31:0] p;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] vz;
    } txn_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [5:0]         seg;
        logic               rerr;
    } spline_res_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic [1:0] mode;
    logic [5:0] knot_index;
    logic [1:0] coef_order;
    logic signed [31:0] param_value;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
    logic out_valid;
    logic out_ready;
    logic signed [31:0] res_x;
    logic signed [31:0] res_y;
    logic signed [31:0] res_z;
    logic [5:0] segment;
    logic range_error;
    logic cfg_we;
    logic [6:0] cfg_wdata;

    // predictor state
    logic signed [31:0] knot_tab [NKNOTS];
    logic signed [31:0] coef_tab [NKNOTS][4][3];
    logic [6:0]         knots_used;

    spline_res_t pending_results[$];
    int  err_count;
    int  items_sent;
    int  results_seen;
    int  range_errs_seen;
    bit  hold_off;
    bit  long_stall_req;

    cubic_spline_segment_evaluator u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .mode(mode), .knot_index(knot_index), .coef_order(coef_order),
        .param_value(param_value), .vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z),
        .out_valid(out_valid), .out_ready(out_ready),
        .res_x(res_x), .res_y(res_y), .res_z(res_z),
        .segment(segment), .range_error(range_error),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("cubic_spline_segment_evaluator_test: errors");
        $finish;
    end

    function automatic longint fl_shift(longint x, int sh);
        return x >>> sh;
    endfunction

    function automatic longint fl_div6(longint x);
        if (x >= 0)
            return x / 6;
        return -((-x + 5) / 6);
    endfunction

    function automatic longint clamp32(longint x);
        if (x > 64'sd2147483647)
            return 64'sd2147483647;
        if (x < -64'sd2147483648)
            return -64'sd2147483648;
        return x;
    endfunction

    // expected result of one query against the predictor's tables
    function automatic spline_res_t eval_spline(logic [1:0] md, logic signed [31:0] pv);
        spline_res_t r;
        int n;
        int s;
        longint d;
        longint q3;
        longint a;
        longint b;
        longint v [3];
        n = knots_used;
        if (n < 2)
            n = 2;
        if (n > NKNOTS)
            n = NKNOTS;
        r = '{x: 0, y: 0, z: 0, seg: 0, rerr: 1'b0};
        if (pv < knot_tab[0] || pv > knot_tab[n-1])
        begin
            r.rerr = 1'b1;
            return r;
        end
        s = 0;
        while (s < n - 1 && knot_tab[s+1] <= pv)
            s++;
        if (s > n - 2)
            s = n - 2;
        d = longint'(pv) - longint'(knot_tab[s]);
        for (int c = 0; c < 3; c++)
        begin
            q3 = fl_shift(longint'(coef_tab[s][3][c]) * d, FB);
            if (md == MODE_VALUE)
            begin
                a = clamp32(fl_div6(3 * longint'(coef_tab[s][2][c]) + q3));
                b = clamp32(longint'(coef_tab[s][1][c]) + fl_shift(a * d, FB));
                v[c] = clamp32(longint'(coef_tab[s][0][c]) + fl_shift(b * d, FB));
            end
            else
            begin
                a = clamp32(longint'(coef_tab[s][2][c]) + fl_shift(q3, 1));
                v[c] = clamp32(longint'(coef_tab[s][1][c]) + fl_shift(a * d, FB));
            end
        end
        r.x = v[0][31:0];
        r.y = v[1][31:0];
        r.z = v[2][31:0];
        r.seg = s[5:0];
        return r;
    endfunction

    function automatic void apply_item(txn_t t);
        if (t.mode == MODE_LOAD)
        begin
            if (t.order == ORDER_POINT)
                knot_tab[t.kidx] = t.p;
            coef_tab[t.kidx][t.order][0] = t.vx;
            coef_tab[t.kidx][t.order][1] = t.vy;
            coef_tab[t.kidx][t.order][2] = t.vz;
        end
        else if (t.mode == MODE_VALUE || t.mode == MODE_GRAD)
        begin
            pending_results.push_back(eval_spline(t.mode, t.p));
        end
    endfunction

    task automatic send_item(txn_t t);
        in_valid    <= 1'b1;
        mode        <= t.mode;
        knot_index  <= t.kidx;
        coef_order  <= t.order;
        param_value <= t.p;
        vec_x       <= t.vx;
        vec_y       <= t.vy;
        vec_z       <= t.vz;
        do
            @(posedge clk);
        while (!in_ready);
        apply_item(t);
        items_sent++;
    endtask

    task automatic idle_input(int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        // a trailing load may still be in the queue or the back end
        repeat (120) @(posedge clk);
    endtask

    task automatic write_knot_count(logic [6:0] val);
        cfg_we    <= 1'b1;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        knots_used = val;
    endtask

    function automatic txn_t load_txn(int k, int ord, logic signed [31:0] p,
                                      logic signed [31:0] x, logic signed [31:0] y,
                                      logic signed [31:0] z);
        txn_t t;
        t = '{mode: MODE_LOAD, kidx: k[5:0], order: ord[1:0], p: p, vx: x, vy: y, vz: z};
        return t;
    endfunction

    function automatic txn_t query_txn(logic [1:0] md, logic signed [31:0] p);
        txn_t t;
        t = '{mode: md, kidx: 6'($urandom()), order: 2'($urandom()), p: p,
              vx: $urandom(), vy: $urandom(), vz: $urandom()};
        return t;
    endfunction

    function automatic logic signed [31:0] rnd_coef();
        case ($urandom_range(0, 5))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2: return $urandom();
            default: return $signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000;
        endcase
    endfunction

    // fills every entry of knots 0..NKNOTS-1
    task automatic load_table(int stride_max, bit wild);
        logic signed [31:0] kp;
        int ords [4];
        kp = wild ? 32'sh8000_0000 + $urandom_range(0, 1000)
                  : $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
        for (int k = 0; k < NKNOTS; k++)
        begin
            ords = '{0, 1, 2, 3};
            ords.shuffle();
            for (int i = 0; i < 4; i++)
            begin
                if (ords[i] == 0)
                    send_item(load_txn(k, 0, kp, rnd_coef(), rnd_coef(), rnd_coef()));
                else
                    send_item(load_txn(k, ords[i], $urandom(), rnd_coef(), rnd_coef(),
                                       rnd_coef()));
                if ($urandom_range(0, 7) == 0)
                    idle_input($urandom_range(1, 6));
            end
            kp = kp + $signed($urandom_range(0, stride_max));
            if (wild && k == NKNOTS - 2)
                kp = 32'sh7FFF_FFF0;
        end
    endtask

    task automatic random_queries(int count);
        int n;
        int burst;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        logic signed [31:0] p;
        n = (knots_used < 2) ? 2 : (knots_used > NKNOTS ? NKNOTS : knots_used);
        lo = knot_tab[0];
        hi = knot_tab[n-1];
        burst = $urandom_range(1, 12);
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(0, 9))
                0: p = $urandom();
                1: p = knot_tab[$urandom_range(0, n - 1)];
                2: p = hi;
                3: p = (lo == 32'sh80000000) ? lo : lo - 1;
                default: p = 32'(lo + longint'($urandom()) % (longint'(hi) - lo + 1));
            endcase
            if ($urandom_range(0, 30) == 0)
                send_item(query_txn(2'd3, p));
            else
                send_item(query_txn($urandom_range(0, 1) ? MODE_VALUE : MODE_GRAD, p));
            if (--burst == 0)
            begin
                burst = $urandom_range(1, 12);
                if ($urandom_range(0, 2) != 0)
                    idle_input($urandom_range(1, 10));
            end
        end
    endtask

    // receiver: stall pattern of its own plus one long hold-off on request
    initial
    begin
        int phase;
        out_ready = 1'b0;
        phase = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_stall_req)
            begin
                long_stall_req = 1'b0;
                out_ready <= 1'b0;
                repeat (400) @(posedge clk);
            end
            phase++;
            if (phase % 300 < 100)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        spline_res_t e;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (range_error)
                range_errs_seen++;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected transaction x=%0d y=%0d z=%0d", $time,
                         res_x, res_y, res_z);
                err_count++;
            end
            else
            begin
                e = pending_results.pop_front();
                if (res_x !== e.x)
                begin
                    $display("%0t: res_x expected %0d actual %0d", $time, e.x, res_x);
                    err_count++;
                end
                if (res_y !== e.y)
                begin
                    $display("%0t: res_y expected %0d actual %0d", $time, e.y, res_y);
                    err_count++;
                end
                if (res_z !== e.z)
                begin
                    $display("%0t: res_z expected %0d actual %0d", $time, e.z, res_z);
                    err_count++;
                end
                if (segment !== e.seg)
                begin
                    $display("%0t: segment expected %0d actual %0d", $time, e.seg, segment);
                    err_count++;
                end
                if (range_error !== e.rerr)
                begin
                    $display("%0t: range_error expected %0b actual %0b", $time, e.rerr,
                             range_error);
                    err_count++;
                end
            end
        end
    end

    // directed rows: checked against a typed-in value where has_exp is set
    typedef struct {
        txn_t        t;
        bit          has_exp;
        spline_res_t exp_res;
    } row_t;

    initial
    begin
        row_t rows [$];
        row_t r;
        spline_res_t got;
        logic [6:0] settings [$];
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        mode        = MODE_LOAD;
        knot_index  = '0;
        coef_order  = '0;
        param_value = '0;
        vec_x       = '0;
        vec_y       = '0;
        vec_z       = '0;
        cfg_we      = 1'b0;
        cfg_wdata   = 7'd2;
        err_count   = 0;
        items_sent  = 0;
        results_seen = 0;
        range_errs_seen = 0;
        long_stall_req = 1'b0;
        knots_used  = 7'd2;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: three knots at 0, 1.0, 2.0 (knot count 2 after reset)
        rows.push_back('{load_txn(0, 0, 32'sh0, 32'sh0001_0000, 32'sh7FFFFFFF,
                                  32'sh80000000), 0, '{0, 0, 0, 0, 0}});
        rows.push_back('{load_txn(0, 1, 0, 32'sh0002_0000, 0, 0), 0, '{0, 0, 0, 0, 0}});
        rows.push_back('{load_txn(0, 2, 0, 32'sh7FFFFFFF, 32'sh80000000, 0), 0,
                         '{0, 0, 0, 0, 0}});
        rows.push_back('{load_txn(0, 3, 0, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000),
                         0, '{0, 0, 0, 0, 0}});
        for (int k = 1; k < 3; k++)
            for (int o = 0; o < 4; o++)
                rows.push_back('{load_txn(k, o, k * 32'sh0001_0000, o * 7, -o, k), 0,
                                 '{0, 0, 0, 0, 0}});
        // at the first knot the value is the point itself
        rows.push_back('{query_txn(MODE_VALUE, 0), 1,
                         '{32'sh0001_0000, 32'sh7FFFFFFF, 32'sh80000000, 0, 0}});
        rows.push_back('{query_txn(MODE_GRAD, 0), 1, '{32'sh0002_0000, 0, 0, 0, 0}});
        // outside the knot range: flag and zeros
        rows.push_back('{query_txn(MODE_VALUE, -1), 1, '{0, 0, 0, 0, 1}});
        rows.push_back('{query_txn(MODE_GRAD, 32'sh80000000), 1, '{0, 0, 0, 0, 1}});
        rows.push_back('{query_txn(MODE_VALUE, 32'sh7FFFFFFF), 1, '{0, 0, 0, 0, 1}});
        rows.push_back('{query_txn(MODE_VALUE, 32'sh0002_0000), 1, '{0, 0, 0, 0, 1}});
        // inside, with saturation, and at the last knot
        rows.push_back('{query_txn(MODE_VALUE, 32'sh0000_8000), 0, '{0, 0, 0, 0, 0}});
        rows.push_back('{query_txn(MODE_GRAD, 32'sh0000_FFFF), 0, '{0, 0, 0, 0, 0}});
        rows.push_back('{query_txn(MODE_VALUE, 32'sh0001_0000), 0, '{0, 0, 0, 0, 0}});
        rows.push_back('{query_txn(MODE_GRAD, 32'sh0001_0000), 0, '{0, 0, 0, 0, 0}});
        // unused mode is ignored
        rows.push_back('{query_txn(2'd3, 32'sh0000_4000), 0, '{0, 0, 0, 0, 0}});

        foreach (rows[i])
        begin
            r = rows[i];
            if (r.t.mode == MODE_VALUE || r.t.mode == MODE_GRAD)
            begin
                got = eval_spline(r.t.mode, r.t.p);
                if (r.has_exp && got != r.exp_res)
                begin
                    $display("%0t: directed row %0d expected x=%0d actual x=%0d", $time,
                             i, r.exp_res.x, got.x);
                    err_count++;
                end
            end
            send_item(r.t);
        end
        drain_results();

        // knot count 3 over the same table, last-knot and out-of-range at the top
        write_knot_count(7'd3);
        send_item(query_txn(MODE_VALUE, 32'sh0002_0000));
        send_item(query_txn(MODE_GRAD, 32'sh0001_8000));
        send_item(query_txn(MODE_VALUE, 32'sh0002_0001));
        drain_results();

        // full table, several knot counts including the extremes and clamped values
        load_table(32'h0000_4000, 1'b0);
        settings = '{7'd64, 7'd2, 7'd0, 7'd127, 7'd33, 7'd65, 7'd17, 7'd1};
        foreach (settings[i])
        begin
            drain_results();
            write_knot_count(settings[i]);
            if (i == 2)
            begin
                // long receiver hold-off while the sender keeps pushing
                long_stall_req = 1'b1;
                random_queries(40);
            end
            random_queries(75);
        end

        // sender waits for every result before going on
        drain_results();
        load_table(32'h7FFF_FFFF, 1'b1);
        drain_results();
        write_knot_count(7'd64);
        random_queries(150);
        drain_results();
        write_knot_count(7'd5);
        random_queries(60);

        drain_results();
        $display("covered %0d transactions in, %0d results out (%0d range errors)",
                 items_sent, results_seen, range_errs_seen);
        $display("knot counts from 0 to 127 with full-table loads and saturating values");
        if (err_count == 0)
            $display("cubic_spline_segment_evaluator_test: clean");
        else
            $display("cubic_spline_segment_evaluator_test: errors");
        $finish;
    end

endmodule

`default_nettype wire

### filelist.f
design/cse_pkg.sv
design/cse_ram.sv
design/cse_front.sv
design/cse_queue.sv
design/cse_back.sv
design/cubic_spline_segment_evaluator.sv
dv/cubic_spline_segment_evaluator_test.sv
